>>> rtl/core/scwt_pkg.sv
// scwt_pkg: types, command and status codes and saturation helpers
// for the stream credit window table; no dependencies
`default_nettype none

package scwt_pkg;

    // table size default
    localparam int MAX_STREAMS_DEF = 16;

    // field widths
    localparam int CMD_W    = 4;
    localparam int SID_W    = 31;
    localparam int WIN_W    = 32;
    localparam int ENTRY_W  = SID_W + WIN_W;

    // window loaded at reset
    localparam logic [SID_W-1:0] INIT_RESET = 31'd65535;

    // credit reported for an untracked stream
    localparam logic signed [WIN_W-1:0] NO_STREAM = -32'sd1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CONN_CHECK   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_CONN_CONSUME = 4'd1;
    localparam logic [CMD_W-1:0] CMD_CONN_UPDATE  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_SET_INIT     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_TRACK        = 4'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE       = 4'd5;
    localparam logic [CMD_W-1:0] CMD_QUERY        = 4'd6;
    localparam logic [CMD_W-1:0] CMD_S_CHECK      = 4'd7;
    localparam logic [CMD_W-1:0] CMD_S_CONSUME    = 4'd8;
    localparam logic [CMD_W-1:0] CMD_S_UPDATE     = 4'd9;

    // status codes
    localparam logic [1:0] ST_DONE        = 2'd0;
    localparam logic [1:0] ST_NOT_TRACKED = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL  = 2'd2;

    // saturation limits on the 34-bit sum
    localparam logic signed [33:0] SUM_MAX = 34'sh07FFFFFFF;
    localparam logic signed [33:0] SUM_MIN = -34'sh080000000;

    // input item
    typedef struct packed {
        logic [3:0]         command;
        logic [30:0]        strm_id;
        logic signed [31:0] amount;
    } t_cmd_in;

    // result item
    typedef struct packed {
        logic [1:0]         status;
        logic               allowed;
        logic signed [31:0] stream_credit;
        logic signed [31:0] conn_credit;
        logic               conn_blocked;
    } t_result;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic check;
        logic exec;
    } t_dp_ctl;

    // saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > SUM_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SUM_MIN) begin
            r = -32'sh80000000;
        end else begin
            r = $signed(v[31:0]);
        end
        return r;
    endfunction

    // clamp to 0 .. 2^31-1
    function automatic logic signed [31:0] clamp_pos(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > SUM_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < 34'sd0) begin
            r = 32'sd0;
        end else begin
            r = $signed(v[31:0]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/scwt_ram.sv
// scwt_ram: generic simple dual-port ram, one write and one registered read
// per cycle; no dependencies
`default_nettype none

module scwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output      logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/core/scwt_ctrl.sv
// scwt_ctrl: command sequencer, runs the table scan and the execute step
// depends on scwt_pkg
`default_nettype none

module scwt_ctrl #(
    parameter int MAX_STREAMS = scwt_pkg::MAX_STREAMS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output      logic                 o_in_ready,
    input  wire logic                 i_out_full,
    output      scwt_pkg::t_dp_ctl    o_ctl,
    output      logic [(MAX_STREAMS > 1 ? $clog2(MAX_STREAMS) : 1)-1:0] o_rd_addr,
    output      logic [(MAX_STREAMS > 1 ? $clog2(MAX_STREAMS) : 1)-1:0] o_chk_idx
);

    import scwt_pkg::*;

    localparam int IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int CNT_W = $clog2(MAX_STREAMS + 1);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_STREAMS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_chk, n_chk;
    logic [IDX_W-1:0] r_chk_idx, n_chk_idx;
    logic             issue;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_chk      = 1'b0;
        n_chk_idx  = r_chk_idx;
        o_in_ready = 1'b0;
        o_ctl      = '0;
        issue      = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                n_cnt      = '0;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // read one entry per cycle, check it in the next cycle
                issue       = (r_cnt != CNT_END);
                o_ctl.check = r_chk;
                n_chk       = issue;
                n_chk_idx   = r_cnt[IDX_W-1:0];
                if (issue) begin
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // wait for room in the output register
                if (!i_out_full) begin
                    o_ctl.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rd_addr = issue ? r_cnt[IDX_W-1:0] : r_chk_idx;
    assign o_chk_idx = r_chk_idx;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_chk     <= 1'b0;
            r_chk_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_chk     <= n_chk;
            r_chk_idx <= n_chk_idx;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/scwt_dp.sv
// scwt_dp: windows, stream table, arithmetic and output register
// depends on scwt_pkg and scwt_ram
`default_nettype none

module scwt_dp #(
    parameter int MAX_STREAMS = scwt_pkg::MAX_STREAMS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire scwt_pkg::t_dp_ctl    i_ctl,
    input  wire logic [(MAX_STREAMS > 1 ? $clog2(MAX_STREAMS) : 1)-1:0] i_rd_addr,
    input  wire logic [(MAX_STREAMS > 1 ? $clog2(MAX_STREAMS) : 1)-1:0] i_chk_idx,
    input  wire scwt_pkg::t_cmd_in    i_in_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [30:0]          i_cfg_wdata,
    input  wire logic                 i_out_ready,
    output      logic                 o_out_full,
    output      logic                 o_out_valid,
    output      scwt_pkg::t_result    o_out_data
);

    import scwt_pkg::*;

    localparam int IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;

    // architectural state
    logic signed [31:0]     r_conn;
    logic signed [31:0]     r_base;
    logic [MAX_STREAMS-1:0] r_valid;

    // current item
    logic [CMD_W-1:0]       r_cmd;
    logic [SID_W-1:0]       r_sid;
    logic signed [31:0]     r_amt;
    logic signed [32:0]     r_delta;

    // scan results
    logic                   r_hit;
    logic [IDX_W-1:0]       r_slot;
    logic signed [31:0]     r_win;
    logic                   r_free_ok;
    logic [IDX_W-1:0]       r_free;

    // output register
    logic                   r_out_valid;
    t_result                r_out, n_out;

    // table ram
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic [ENTRY_W-1:0]     ram_rdata;

    scwt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_STREAMS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_rdata)
    );

    // check of the entry read last cycle
    logic [SID_W-1:0]   rd_id;
    logic signed [31:0] rd_win;
    logic               rd_v;
    logic               rd_hit;
    logic signed [31:0] shift_win;

    assign rd_id     = ram_rdata[ENTRY_W-1:WIN_W];
    assign rd_win    = $signed(ram_rdata[WIN_W-1:0]);
    assign rd_v      = r_valid[i_chk_idx];
    assign rd_hit    = rd_v && (rd_id == r_sid);
    assign shift_win = sat32({{2{rd_win[31]}}, rd_win} + {r_delta[32], r_delta});

    // shared adder for the execute step
    logic               stream_op;
    logic signed [31:0] a_src;
    logic signed [33:0] b_op;
    logic signed [33:0] sum;
    logic signed [31:0] sum_sat;
    logic signed [31:0] sum_clp;
    logic               ge;

    assign stream_op = (r_cmd == CMD_S_CHECK) || (r_cmd == CMD_S_CONSUME) ||
                       (r_cmd == CMD_S_UPDATE);
    assign a_src     = stream_op ? r_win : r_conn;

    always_comb begin
        case (r_cmd)
            CMD_CONN_CONSUME, CMD_S_CONSUME: b_op = -{{2{r_amt[31]}}, r_amt};
            CMD_SET_INIT:                    b_op = {r_delta[32], r_delta};
            default:                         b_op = {{2{r_amt[31]}}, r_amt};
        endcase
    end

    assign sum     = {{2{a_src[31]}}, a_src} + b_op;
    assign sum_sat = sat32(sum);
    assign sum_clp = clamp_pos(sum);
    assign ge      = (a_src >= r_amt);

    // execute step: result and state updates
    logic signed [31:0] n_conn;
    logic               ex_we;
    logic [IDX_W-1:0]   ex_waddr;
    logic signed [31:0] ex_wwin;
    logic               set_valid;
    logic               clr_valid;

    always_comb begin
        n_conn    = r_conn;
        ex_we     = 1'b0;
        ex_waddr  = r_slot;
        ex_wwin   = r_win;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        n_out.status        = ST_DONE;
        n_out.allowed       = 1'b0;
        n_out.stream_credit = r_hit ? r_win : NO_STREAM;
        case (r_cmd)
            CMD_CONN_CHECK: begin
                n_out.allowed = ge;
            end
            CMD_CONN_CONSUME: begin
                n_conn = sum_sat;
            end
            CMD_CONN_UPDATE: begin
                n_conn = sum_clp;
            end
            CMD_SET_INIT: begin
                n_conn = sum_sat;
            end
            CMD_TRACK: begin
                if (!r_hit) begin
                    if (r_free_ok) begin
                        ex_we               = 1'b1;
                        ex_waddr            = r_free;
                        ex_wwin             = r_base;
                        set_valid           = 1'b1;
                        n_out.stream_credit = r_base;
                    end else begin
                        n_out.status = ST_TABLE_FULL;
                    end
                end
            end
            CMD_REMOVE: begin
                n_out.stream_credit = NO_STREAM;
                if (r_hit) begin
                    clr_valid = 1'b1;
                end else begin
                    n_out.status = ST_NOT_TRACKED;
                end
            end
            CMD_QUERY: begin
                if (!r_hit) begin
                    n_out.status = ST_NOT_TRACKED;
                end
            end
            CMD_S_CHECK: begin
                if (r_hit) begin
                    n_out.allowed = ge;
                end else begin
                    n_out.status = ST_NOT_TRACKED;
                end
            end
            CMD_S_CONSUME, CMD_S_UPDATE: begin
                if (r_hit) begin
                    ex_we               = 1'b1;
                    ex_wwin             = (r_cmd == CMD_S_CONSUME) ? sum_sat : sum_clp;
                    n_out.stream_credit = ex_wwin;
                end else begin
                    n_out.status = ST_NOT_TRACKED;
                end
            end
            default: begin
            end
        endcase
        n_out.conn_credit  = n_conn;
        n_out.conn_blocked = (n_conn <= 32'sd0);
    end

    // table write: shift valid entries during the scan of a set-init command, update in the execute step
    always_comb begin
        if (i_ctl.check) begin
            ram_we    = (r_cmd == CMD_SET_INIT) && rd_v;
            ram_waddr = i_chk_idx;
            ram_wdata = {rd_id, shift_win};
        end else begin
            ram_we    = i_ctl.exec && ex_we;
            ram_waddr = ex_waddr;
            ram_wdata = {r_sid, ex_wwin};
        end
    end

    // item and scan registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd     <= i_in_data.command;
            r_sid     <= i_in_data.strm_id;
            r_amt     <= i_in_data.amount;
            r_delta   <= {i_in_data.amount[31], i_in_data.amount} - {r_base[31], r_base};
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (i_ctl.check) begin
            if (rd_hit) begin
                r_hit  <= 1'b1;
                r_slot <= i_chk_idx;
                r_win  <= (r_cmd == CMD_SET_INIT) ? shift_win : rd_win;
            end
            if (!rd_v && !r_free_ok) begin
                r_free_ok <= 1'b1;
                r_free    <= i_chk_idx;
            end
        end
    end

    // windows and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn  <= $signed({1'b0, INIT_RESET});
            r_base  <= $signed({1'b0, INIT_RESET});
            r_valid <= '0;
        end else if (i_cfg_we) begin
            r_conn  <= $signed({1'b0, i_cfg_wdata});
            r_base  <= $signed({1'b0, i_cfg_wdata});
            r_valid <= '0;
        end else if (i_ctl.exec) begin
            r_conn <= n_conn;
            if (r_cmd == CMD_SET_INIT) begin
                r_base <= r_amt;
            end
            if (set_valid) begin
                r_valid[r_free] <= 1'b1;
            end
            if (clr_valid) begin
                r_valid[r_slot] <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_out <= n_out;
        end
    end

    assign o_out_full  = r_out_valid && !i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> rtl/core/stream_credit_window_table.sv
// stream_credit_window_table: a table scan reads one ram entry per cycle and
// compares its stream id, then an execute step writes the result, waiting while
// the output is full; a new item is accepted only once the execute step is done
// reset: connection and baseline windows load 65535 and every table entry is
// invalid at once, with no clearing pass; config writes do the same with their value
// depends on scwt_pkg, scwt_ctrl, scwt_dp, scwt_ram
`default_nettype none

module stream_credit_window_table #(
    parameter int MAX_STREAMS = scwt_pkg::MAX_STREAMS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output      logic                o_in_ready,
    input  wire scwt_pkg::t_cmd_in   i_in_data,
    output      logic                o_out_valid,
    input  wire logic                i_out_ready,
    output      scwt_pkg::t_result   o_out_data,
    input  wire logic                i_cfg_we,
    input  wire logic [30:0]         i_cfg_wdata
);

    import scwt_pkg::*;

    localparam int IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;

    t_dp_ctl          ctl;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] chk_idx;
    logic             out_full;

    // sequencer
    scwt_ctrl #(
        .MAX_STREAMS (MAX_STREAMS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_out_full (out_full),
        .o_ctl      (ctl),
        .o_rd_addr  (rd_addr),
        .o_chk_idx  (chk_idx)
    );

    // windows and stream table
    scwt_dp #(
        .MAX_STREAMS (MAX_STREAMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_rd_addr   (rd_addr),
        .i_chk_idx   (chk_idx),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_out_ready),
        .o_out_full  (out_full),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
